@@ hdl/clrr_pkg.sv @@
// Shared types, screen geometry and command codes for the line and rectangle rasterizer.
// No dependencies; every other file of the block imports this package.
package clrr_pkg;

   // Screen geometry and derived widths.
   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 192;
   localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int X_BITS        = $clog2(SCREEN_WIDTH);
   localparam int Y_BITS        = $clog2(SCREEN_HEIGHT);
   localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
   localparam int COLOR_BITS    = 16;

   // Outline edges reach x + w - 1, which needs one bit beyond the 12-bit inputs; two are given.
   localparam int COORD_BITS    = 14;
   localparam int ERR_BITS      = 16;

   // Command codes.
   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_PLOT  = 3'd1;
   localparam logic [2:0] CMD_LINE  = 3'd2;
   localparam logic [2:0] CMD_RECT  = 3'd3;
   localparam logic [2:0] CMD_FILL  = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   // Request and response words.
   typedef struct packed {
      logic [2:0]         command;
      logic signed [11:0] x_start;
      logic signed [11:0] y_start;
      logic signed [11:0] x_end;
      logic signed [11:0] y_end;
      logic [10:0]        rect_width;
      logic [10:0]        rect_height;
      logic [15:0]        color;
   } req_word_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        read_valid;
   } rsp_word_type;

   // Control from the sequencer to the line stepper, and the pixels it emits.
   typedef struct packed {
      logic      start;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } line_cmd_type;

   typedef struct packed {
      logic      valid;
      logic      last;
      coord_type x;
      coord_type y;
   } line_pix_type;

   typedef enum logic [1:0] {
      LS_IDLE,
      LS_SETUP,
      LS_RUN
   } line_state_type;

   typedef enum logic [3:0] {
      TS_INIT,
      TS_IDLE,
      TS_CLEAR,
      TS_PLOT,
      TS_LINE_LOAD,
      TS_LINE_RUN,
      TS_FILL_SETUP,
      TS_FILL_RUN,
      TS_READ,
      TS_DONE
   } top_state_type;

endpackage

@@ hdl/clrr_line_step.sv @@
// Bresenham line stepper: emits one pixel coordinate per cycle between inclusive endpoints.
// Depends on clrr_pkg for coordinate, command and pixel types.
module clrr_line_step import clrr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  line_cmd_type line_cmd,
   output line_pix_type line_pix
);

   localparam coord_type ONE_C = coord_type'(1);

   line_state_type state_ff, state_in;
   coord_type      xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   err_type        ddx_ff, ddx_in, ddy_ff, ddy_in, acc_ff, acc_in;
   logic           stx_neg_ff, stx_neg_in, sty_neg_ff, sty_neg_in;

   err_type        dx_diff, dy_diff, dx_abs, dy_abs, twice;
   logic           at_end, step_x, step_y;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      xb_ff      <= xb_in;
      yb_ff      <= yb_in;
      ddx_ff     <= ddx_in;
      ddy_ff     <= ddy_in;
      acc_ff     <= acc_in;
      stx_neg_ff <= stx_neg_in;
      sty_neg_ff <= sty_neg_in;
   end

   // Distances and the error test of one step.
   always_comb begin
      dx_diff = err_type'(xb_ff) - err_type'(xa_ff);
      dy_diff = err_type'(yb_ff) - err_type'(ya_ff);
      dx_abs  = dx_diff[ERR_BITS-1] ? -dx_diff : dx_diff;
      dy_abs  = dy_diff[ERR_BITS-1] ? -dy_diff : dy_diff;
      twice   = acc_ff <<< 1;
      step_x  = twice > -ddy_ff;
      step_y  = twice < ddx_ff;
      at_end  = (xa_ff == xb_ff) && (ya_ff == yb_ff);
   end

   // Sequencer: load endpoints, derive deltas, then step until the end pixel.
   always_comb begin
      state_in   = state_ff;
      xa_in      = xa_ff;
      ya_in      = ya_ff;
      xb_in      = xb_ff;
      yb_in      = yb_ff;
      ddx_in     = ddx_ff;
      ddy_in     = ddy_ff;
      acc_in     = acc_ff;
      stx_neg_in = stx_neg_ff;
      sty_neg_in = sty_neg_ff;
      line_pix   = '0;
      case (state_ff)
         LS_IDLE: begin
            if (line_cmd.start) begin
               xa_in    = line_cmd.x0;
               ya_in    = line_cmd.y0;
               xb_in    = line_cmd.x1;
               yb_in    = line_cmd.y1;
               state_in = LS_SETUP;
            end
         end
         LS_SETUP: begin
            ddx_in     = dx_abs;
            ddy_in     = dy_abs;
            acc_in     = dx_abs - dy_abs;
            stx_neg_in = !(xa_ff < xb_ff);
            sty_neg_in = !(ya_ff < yb_ff);
            state_in   = LS_RUN;
         end
         LS_RUN: begin
            line_pix.valid = 1'b1;
            line_pix.last  = at_end;
            line_pix.x     = xa_ff;
            line_pix.y     = ya_ff;
            if (at_end) begin
               state_in = LS_IDLE;
            end else begin
               acc_in = acc_ff - (step_x ? ddy_ff : '0) + (step_y ? ddx_ff : '0);
               if (step_x) begin
                  xa_in = stx_neg_ff ? xa_ff - ONE_C : xa_ff + ONE_C;
               end
               if (step_y) begin
                  ya_in = sty_neg_ff ? ya_ff - ONE_C : ya_ff + ONE_C;
               end
            end
         end
         default: begin
            state_in = LS_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/clipped_line_rect_rasterizer_core.sv @@
// Top level of the rasterizer: command sequencer, 16-bit frame store and response register.
// Depends on clrr_pkg and on clrr_line_step for line and outline drawing.
//
// A command word is taken when start is high and busy is low; the block then runs it alone,
// writing at most one pixel per cycle through the single write port of the frame store, and
// ends it with a one-cycle rsp_strobe carrying the response word, which the receiver cannot
// hold off. After reset the store is swept to zero at one pixel per cycle, and busy stays
// high until all SCREEN_WIDTH * SCREEN_HEIGHT (49152) pixels are written; only then is the
// first command taken. A line steps every pixel between its endpoints but writes only the
// on-screen ones; an outline draws its top, bottom, left and right edges as such lines; a fill
// writes each pixel of the clipped area.
module clipped_line_rect_rasterizer_core import clrr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam coord_type ONE_C   = coord_type'(1);
   localparam coord_type SCR_W_C = coord_type'(SCREEN_WIDTH);
   localparam coord_type SCR_H_C = coord_type'(SCREEN_HEIGHT);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(STORE_DEPTH - 1);

   // Frame store address of an on-screen pixel.
   function automatic logic [ADDR_BITS-1:0] pix_addr(input logic [X_BITS-1:0] px,
                                                     input logic [Y_BITS-1:0] py);
      pix_addr = ADDR_BITS'(py) * ADDR_BITS'(SCREEN_WIDTH) + ADDR_BITS'(px);
   endfunction

   function automatic logic on_screen(input coord_type px, input coord_type py);
      on_screen = !px[COORD_BITS-1] && (px < SCR_W_C) && !py[COORD_BITS-1] && (py < SCR_H_C);
   endfunction

   top_state_type           state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic [1:0]              seg_ff, seg_in;
   req_word_type            req_ff, req_in;
   logic                    rvalid_ff, rvalid_in;
   logic [X_BITS-1:0]       fx_ff, fx_in, fill_x0_ff, fill_x0_in, fill_xl_ff, fill_xl_in;
   logic [Y_BITS-1:0]       fy_ff, fy_in, fill_yl_ff, fill_yl_in;
   logic [COLOR_BITS-1:0]   rd_data_ff;

   logic                    wr_en, rd_en;
   logic [ADDR_BITS-1:0]    wr_addr, rd_addr;
   logic [COLOR_BITS-1:0]   wr_data;

   line_cmd_type            line_cmd;
   line_pix_type            line_pix;

   coord_type               xs, ys, xr, yb, fx0, fy0, fx1, fy1, fx1_last, fy1_last;

   logic [COLOR_BITS-1:0]   store_mem [STORE_DEPTH];

   clrr_line_step u_line_step (
      .clock    (clock),
      .reset    (reset),
      .line_cmd (line_cmd),
      .line_pix (line_pix)
   );

   // Frame store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Control state; the reset sweep starts at address zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_INIT;
         clr_ff   <= '0;
         seg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         seg_ff   <= seg_in;
      end
   end

   // Command word and fill scan registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rvalid_ff  <= rvalid_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      fill_x0_ff <= fill_x0_in;
      fill_xl_ff <= fill_xl_in;
      fill_yl_ff <= fill_yl_in;
   end

   // Edge coordinates at full precision, and the clipped fill bounds.
   always_comb begin
      xs  = coord_type'(req_ff.x_start);
      ys  = coord_type'(req_ff.y_start);
      xr  = xs + coord_type'(req_ff.rect_width) - ONE_C;
      yb  = ys + coord_type'(req_ff.rect_height) - ONE_C;
      fx0 = xs[COORD_BITS-1] ? '0 : xs;
      fy0 = ys[COORD_BITS-1] ? '0 : ys;
      fx1 = xs + coord_type'(req_ff.rect_width);
      fy1 = ys + coord_type'(req_ff.rect_height);
      if (fx1 > SCR_W_C) begin
         fx1 = SCR_W_C;
      end
      if (fy1 > SCR_H_C) begin
         fy1 = SCR_H_C;
      end
      fx1_last = fx1 - ONE_C;
      fy1_last = fy1 - ONE_C;
   end

   // Sequencer: next state, store port control and response.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      seg_in     = seg_ff;
      req_in     = req_ff;
      rvalid_in  = rvalid_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      fill_x0_in = fill_x0_ff;
      fill_xl_in = fill_xl_ff;
      fill_yl_in = fill_yl_ff;
      wr_en      = 1'b0;
      wr_addr    = clr_ff;
      wr_data    = req_ff.color;
      rd_en      = 1'b0;
      rd_addr    = pix_addr(xs[X_BITS-1:0], ys[Y_BITS-1:0]);
      line_cmd   = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rsp_word   = '0;
      case (state_ff)
         TS_INIT: begin
            wr_en   = 1'b1;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = TS_IDLE;
            end
         end
         TS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               req_in    = req_word;
               rvalid_in = 1'b0;
               clr_in    = '0;
               seg_in    = '0;
               case (req_word.command)
                  CMD_CLEAR: state_in = TS_CLEAR;
                  CMD_PLOT:  state_in = TS_PLOT;
                  CMD_LINE:  state_in = TS_LINE_LOAD;
                  CMD_RECT:  state_in = TS_LINE_LOAD;
                  CMD_FILL:  state_in = TS_FILL_SETUP;
                  CMD_READ:  state_in = TS_READ;
                  default:   state_in = TS_DONE;
               endcase
            end
         end
         TS_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = TS_DONE;
            end
         end
         TS_PLOT: begin
            wr_en    = on_screen(xs, ys);
            wr_addr  = pix_addr(xs[X_BITS-1:0], ys[Y_BITS-1:0]);
            state_in = TS_DONE;
         end
         TS_LINE_LOAD: begin
            // The outline runs top, bottom, left, then right edge.
            line_cmd.start = 1'b1;
            if (req_ff.command == CMD_RECT) begin
               case (seg_ff)
                  2'd0: begin
                     line_cmd.x0 = xs;
                     line_cmd.y0 = ys;
                     line_cmd.x1 = xr;
                     line_cmd.y1 = ys;
                  end
                  2'd1: begin
                     line_cmd.x0 = xs;
                     line_cmd.y0 = yb;
                     line_cmd.x1 = xr;
                     line_cmd.y1 = yb;
                  end
                  2'd2: begin
                     line_cmd.x0 = xs;
                     line_cmd.y0 = ys;
                     line_cmd.x1 = xs;
                     line_cmd.y1 = yb;
                  end
                  default: begin
                     line_cmd.x0 = xr;
                     line_cmd.y0 = ys;
                     line_cmd.x1 = xr;
                     line_cmd.y1 = yb;
                  end
               endcase
            end else begin
               line_cmd.x0 = xs;
               line_cmd.y0 = ys;
               line_cmd.x1 = coord_type'(req_ff.x_end);
               line_cmd.y1 = coord_type'(req_ff.y_end);
            end
            state_in = TS_LINE_RUN;
         end
         TS_LINE_RUN: begin
            wr_en   = line_pix.valid && on_screen(line_pix.x, line_pix.y);
            wr_addr = pix_addr(line_pix.x[X_BITS-1:0], line_pix.y[Y_BITS-1:0]);
            if (line_pix.valid && line_pix.last) begin
               if ((req_ff.command == CMD_RECT) && (seg_ff != 2'd3)) begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = TS_LINE_LOAD;
               end else begin
                  state_in = TS_DONE;
               end
            end
         end
         TS_FILL_SETUP: begin
            fill_x0_in = fx0[X_BITS-1:0];
            fill_xl_in = fx1_last[X_BITS-1:0];
            fill_yl_in = fy1_last[Y_BITS-1:0];
            fx_in      = fx0[X_BITS-1:0];
            fy_in      = fy0[Y_BITS-1:0];
            if ((fx1 <= fx0) || (fy1 <= fy0)) begin
               state_in = TS_DONE;
            end else begin
               state_in = TS_FILL_RUN;
            end
         end
         TS_FILL_RUN: begin
            // Row-major scan of the clipped area.
            wr_en   = 1'b1;
            wr_addr = pix_addr(fx_ff, fy_ff);
            if (fx_ff == fill_xl_ff) begin
               fx_in = fill_x0_ff;
               if (fy_ff == fill_yl_ff) begin
                  state_in = TS_DONE;
               end else begin
                  fy_in = fy_ff + 1'b1;
               end
            end else begin
               fx_in = fx_ff + 1'b1;
            end
         end
         TS_READ: begin
            rd_en     = 1'b1;
            rvalid_in = on_screen(xs, ys);
            state_in  = TS_DONE;
         end
         TS_DONE: begin
            rsp_strobe          = 1'b1;
            rsp_word.read_valid = rvalid_ff;
            rsp_word.read_data  = rvalid_ff ? rd_data_ff : '0;
            state_in            = TS_IDLE;
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

endmodule

@@ bench/clrr_checker.sv @@
// Response checker for the line and rectangle rasterizer: keeps its own frame store and
// predicts every response word. Depends on clrr_pkg for the word types and command codes.
`timescale 1ns / 100ps

module clrr_checker import clrr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending_count
);

   // Shadow copy of the frame store, row by row.
   logic [COLOR_BITS-1:0] shadow_frame [STORE_DEPTH];
   rsp_word_type          queued_rsp_words [$];
   int                    mismatch_total = 0;
   int                    queued_total   = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = queued_total;

   function automatic bit on_screen(int x, int y);
      return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
   endfunction

   function automatic void put_pixel(int x, int y, logic [COLOR_BITS-1:0] c);
      if (on_screen(x, y)) begin
         shadow_frame[y * SCREEN_WIDTH + x] = c;
      end
   endfunction

   // Bresenham stepping with both ends included; off-screen pixels are dropped.
   function automatic void trace_line(int xa, int ya, int xb, int yb,
                                      logic [COLOR_BITS-1:0] c);
      int ddx;
      int ddy;
      int stx;
      int sty;
      int acc;
      int twice;
      bit done;
      ddx  = (xb > xa) ? xb - xa : xa - xb;
      ddy  = (yb > ya) ? yb - ya : ya - yb;
      stx  = (xa < xb) ? 1 : -1;
      sty  = (ya < yb) ? 1 : -1;
      acc  = ddx - ddy;
      done = 1'b0;
      while (!done) begin
         put_pixel(xa, ya, c);
         if (xa == xb && ya == yb) begin
            done = 1'b1;
         end else begin
            twice = 2 * acc;
            if (twice > -ddy) begin
               acc -= ddy;
               xa  += stx;
            end
            if (twice < ddx) begin
               acc += ddx;
               ya  += sty;
            end
         end
      end
   endfunction

   // Applies one command word to the shadow frame and returns the response it must give.
   function automatic rsp_word_type raster_command(req_word_type w);
      rsp_word_type rsp;
      int xs;
      int ys;
      int xe;
      int ye;
      int wd;
      int ht;
      int x0;
      int y0;
      int x1;
      int y1;
      rsp = '0;
      xs  = $signed(w.x_start);
      ys  = $signed(w.y_start);
      xe  = $signed(w.x_end);
      ye  = $signed(w.y_end);
      wd  = w.rect_width;
      ht  = w.rect_height;
      case (w.command)
         CMD_CLEAR: begin
            foreach (shadow_frame[i]) shadow_frame[i] = w.color;
         end
         CMD_PLOT: begin
            put_pixel(xs, ys, w.color);
         end
         CMD_LINE: begin
            trace_line(xs, ys, xe, ye, w.color);
         end
         CMD_RECT: begin
            // Edges run to x+w-1 and y+h-1 even when that lies before the start.
            trace_line(xs, ys, xs + wd - 1, ys, w.color);
            trace_line(xs, ys + ht - 1, xs + wd - 1, ys + ht - 1, w.color);
            trace_line(xs, ys, xs, ys + ht - 1, w.color);
            trace_line(xs + wd - 1, ys, xs + wd - 1, ys + ht - 1, w.color);
         end
         CMD_FILL: begin
            x0 = (xs < 0) ? 0 : xs;
            y0 = (ys < 0) ? 0 : ys;
            x1 = (xs + wd > SCREEN_WIDTH) ? SCREEN_WIDTH : xs + wd;
            y1 = (ys + ht > SCREEN_HEIGHT) ? SCREEN_HEIGHT : ys + ht;
            for (int iy = y0; iy < y1; iy++) begin
               for (int ix = x0; ix < x1; ix++) begin
                  shadow_frame[iy * SCREEN_WIDTH + ix] = w.color;
               end
            end
         end
         CMD_READ: begin
            if (on_screen(xs, ys)) begin
               rsp.read_data  = shadow_frame[ys * SCREEN_WIDTH + xs];
               rsp.read_valid = 1'b1;
            end
         end
         default: begin
            // Spare codes write nothing and answer with an empty word.
         end
      endcase
      return rsp;
   endfunction

   // Responses are compared before a word taken at the same edge is predicted.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (shadow_frame[i]) shadow_frame[i] = '0;
         queued_rsp_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (queued_rsp_words.size() == 0) begin
               $error("response word with none expected: read_data %h read_valid %b",
                      rsp_word.read_data, rsp_word.read_valid);
               mismatch_total++;
            end else begin
               want = queued_rsp_words.pop_front();
               if (rsp_word.read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h",
                         want.read_data, rsp_word.read_data);
                  mismatch_total++;
               end
               if (rsp_word.read_valid !== want.read_valid) begin
                  $error("read_valid: expected %b, actual %b",
                         want.read_valid, rsp_word.read_valid);
                  mismatch_total++;
               end
            end
         end
         if (start && !busy) begin
            queued_rsp_words.push_back(raster_command(req_word));
         end
      end
      queued_total <= queued_rsp_words.size();
   end

endmodule

@@ bench/clipped_line_rect_rasterizer_core_tb.sv @@
// Top of the rasterizer testbench: clock, reset, directed and random command words.
// Depends on clrr_pkg, the rasterizer core and clrr_checker, which does all the comparing.
`timescale 1ns / 100ps

module clipped_line_rect_rasterizer_core_tb;
   import clrr_pkg::*;

   // Codes the block does not define.
   localparam logic [2:0] CMD_SPARE_6  = 3'd6;
   localparam logic [2:0] CMD_SPARE_7  = 3'd7;
   localparam int         RANDOM_WORDS = 1525;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending_count;
   int           burst_left;
   int           last_x;
   int           last_y;

   clipped_line_rect_rasterizer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   clrr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run, reset sweep included.
   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic req_word_type build_word(logic [2:0] cmd, int xs, int ys, int xe,
                                               int ye, int wd, int ht, int c);
      req_word_type w;
      w.command     = cmd;
      w.x_start     = 12'(xs);
      w.y_start     = 12'(ys);
      w.x_end       = 12'(xe);
      w.y_end       = 12'(ye);
      w.rect_width  = 11'(wd);
      w.rect_height = 11'(ht);
      w.color       = 16'(c);
      return w;
   endfunction

   // Mostly near the screen with a margin; now and then anywhere in the 12-bit range.
   function automatic int pick_coord(int span);
      if ($urandom_range(99) < 6) begin
         return int'($urandom_range(4095)) - 2048;
      end
      return int'($urandom_range(span + 39)) - 20;
   endfunction

   // Mostly small rectangles, some empty ones, and a few of any size up to the largest.
   function automatic int pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         return $urandom_range(2047);
      end else if (r < 10) begin
         return 0;
      end
      return $urandom_range(1, 40);
   endfunction

   // Waits a random gap, sometimes counted from the end of the previous command, then
   // presents the word until it is taken. Start stays high when no gap follows.
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(39) == 0) begin
         burst_left = $urandom_range(10, 40);
         gap        = 0;
      end else begin
         gap = $urandom_range(16);
      end
      if (gap > 0) begin
         start <= 1'b0;
         if ($urandom_range(1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int          r;
      int          xs;
      int          ys;
      int          xe;
      int          ye;
      int          wd;
      int          ht;
      logic [2:0]  cmd;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_word   <= '0;
      burst_left = 0;
      last_x     = 0;
      last_y     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: store contents after reset, screen corners and off-screen plots.
      send_word(build_word(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      send_word(build_word(CMD_PLOT, 0, 0, 0, 0, 0, 0, 'hFFFF));
      send_word(build_word(CMD_PLOT, 255, 191, 0, 0, 0, 0, 'h8001));
      send_word(build_word(CMD_PLOT, -1, 5, 0, 0, 0, 0, 'h1111));
      send_word(build_word(CMD_PLOT, 256, 0, 0, 0, 0, 0, 'h2222));
      send_word(build_word(CMD_PLOT, -2048, 2047, 0, 0, 0, 0, 'h3333));
      send_word(build_word(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      send_word(build_word(CMD_READ, 255, 191, 0, 0, 0, 0, 0));
      send_word(build_word(CMD_READ, -1, 0, 0, 0, 0, 0, 0));
      send_word(build_word(CMD_READ, 2047, -2048, 0, 0, 0, 0, 0));

      // Lines: full diagonal, steep reversed, a single point, and one that crosses the
      // whole coordinate range.
      send_word(build_word(CMD_LINE, 0, 0, 255, 191, 0, 0, 'h0F0F));
      send_word(build_word(CMD_LINE, 30, 180, 20, 2, 0, 0, 'hA5A5));
      send_word(build_word(CMD_LINE, 100, 100, 100, 100, 0, 0, 'h5A5A));
      send_word(build_word(CMD_LINE, -2048, -2048, 2047, 2047, 0, 0, 'h7FFE));
      send_word(build_word(CMD_READ, 128, 96, 0, 0, 0, 0, 0));

      // Outlines of zero size, unit size, and with edges beyond the 12-bit range.
      send_word(build_word(CMD_RECT, 10, 10, 0, 0, 0, 0, 'hC001));
      send_word(build_word(CMD_RECT, 40, 40, 0, 0, 1, 1, 'hC002));
      send_word(build_word(CMD_RECT, 2047, 2047, 0, 0, 2047, 2047, 'hC003));
      send_word(build_word(CMD_RECT, -2048, -2048, 0, 0, 2047, 2047, 'hC004));

      // Fills: zero width, clipped at the top left, and clipped at the far corner.
      send_word(build_word(CMD_FILL, 50, 50, 0, 0, 0, 5, 'hBEEF));
      send_word(build_word(CMD_FILL, -5, -5, 0, 0, 20, 20, 'hD00D));
      send_word(build_word(CMD_FILL, 200, 150, 0, 0, 2047, 2047, 'h0001));

      // Spare codes, then a clear and a read of its result.
      send_word(build_word(CMD_SPARE_6, 1, 1, 1, 1, 1, 1, 'hFFFF));
      send_word(build_word(CMD_SPARE_7, 2, 2, 2, 2, 2, 2, 'hFFFF));
      send_word(build_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 'h1234));
      send_word(build_word(CMD_READ, 128, 96, 0, 0, 0, 0, 0));

      // Random words: drawing mixed with reads, many of them of the last drawn spot.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         r  = $urandom_range(999);
         xs = pick_coord(SCREEN_WIDTH);
         ys = pick_coord(SCREEN_HEIGHT);
         if ($urandom_range(9) < 8) begin
            xe = xs + int'($urandom_range(128)) - 64;
            ye = ys + int'($urandom_range(128)) - 64;
         end else begin
            xe = pick_coord(SCREEN_WIDTH);
            ye = pick_coord(SCREEN_HEIGHT);
         end
         wd = pick_size();
         ht = pick_size();
         if (r < 4) begin
            cmd = CMD_CLEAR;
         end else if (r < 200) begin
            cmd = CMD_PLOT;
         end else if (r < 550) begin
            cmd = CMD_READ;
            if ($urandom_range(9) < 4) begin
               xs = last_x;
               ys = last_y;
            end else if ($urandom_range(9) < 9) begin
               xs = $urandom_range(SCREEN_WIDTH - 1);
               ys = $urandom_range(SCREEN_HEIGHT - 1);
            end
         end else if (r < 730) begin
            cmd = CMD_LINE;
         end else if (r < 840) begin
            cmd = CMD_RECT;
         end else if (r < 960) begin
            cmd = CMD_FILL;
         end else begin
            cmd = ($urandom_range(1) == 1) ? CMD_SPARE_7 : CMD_SPARE_6;
         end
         if (cmd != CMD_READ) begin
            last_x = xs;
            last_y = ys;
         end
         send_word(build_word(cmd, xs, ys, xe, ye, wd, ht, $urandom));
      end

      // Drain: lower start, let pending_count take in the last word, then wait for every response.
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/clrr_pkg.sv
hdl/clrr_line_step.sv
hdl/clipped_line_rect_rasterizer_core.sv
bench/clrr_checker.sv
bench/clipped_line_rect_rasterizer_core_tb.sv
